// ----- rtl/core/tcw_pkg.sv -----
package tcw_pkg;

    localparam int CMD_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int COORD_W  = 8;
    localparam int DATA_W   = 16;
    localparam int CURSOR_W = 11;

    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [DATA_W-1:0] BLANK_CELL   = 16'h0020;
    localparam logic [DATA_W-1:0] ERR_DATA     = 16'hFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SWEEP,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic put_pos;
        logic write_now;
        logic write_late;
        logic sweep_start;
        logic sweep_copy;
        logic sweep_step;
        logic clear_pos;
        logic read_issue;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_put;
        logic is_clear;
        logic is_read;
        logic is_newline;
        logic need_scroll;
        logic sweep_done;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/tcw_if.sv -----
interface tcw_item_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CMD_W-1:0]     cmd;
    logic [tcw_pkg::CHAR_W-1:0]    char_code;
    logic [tcw_pkg::COLOR_W-1:0]   fg_color;
    logic [tcw_pkg::COLOR_W-1:0]   bg_color;
    logic [tcw_pkg::COORD_W-1:0]   read_row;
    logic [tcw_pkg::COORD_W-1:0]   read_col;

    modport source (
        output valid, cmd, char_code, fg_color, bg_color, read_row, read_col,
        input  ready
    );

    modport sink (
        input  valid, cmd, char_code, fg_color, bg_color, read_row, read_col,
        output ready
    );
endinterface

interface tcw_result_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::DATA_W-1:0]    read_data;
    logic [tcw_pkg::CURSOR_W-1:0]  cursor_pos;
    logic                          range_error;

    modport source (
        output valid, read_data, cursor_pos, range_error,
        input  ready
    );

    modport sink (
        input  valid, read_data, cursor_pos, range_error,
        output ready
    );
endinterface

// ----- rtl/core/tcw_ctrl.sv -----
module tcw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  tcw_pkg::dp_status_t   sts,
    output tcw_pkg::ctrl_cmd_t    cmd
);

    tcw_pkg::state_t state_reg;
    tcw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        item_ready = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            tcw_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = tcw_pkg::ST_DECODE;
                end
            end
            tcw_pkg::ST_DECODE:
            begin
                priority if (sts.is_clear)
                begin
                    cmd.clear_pos   = 1'b1;
                    cmd.sweep_start = 1'b1;
                    state_next      = tcw_pkg::ST_SWEEP;
                end
                else if (sts.is_read)
                begin
                    cmd.read_issue = 1'b1;
                    state_next     = tcw_pkg::ST_DONE;
                end
                else if (sts.is_put && sts.need_scroll)
                begin
                    cmd.put_pos     = 1'b1;
                    cmd.sweep_start = 1'b1;
                    cmd.sweep_copy  = 1'b1;
                    state_next      = tcw_pkg::ST_SWEEP;
                end
                else
                begin
                    // plain put, newline or unused command
                    cmd.put_pos   = sts.is_put;
                    cmd.write_now = sts.is_put && !sts.is_newline;
                    if (sts.out_free)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = tcw_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                end
            end
            tcw_pkg::ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done)
                begin
                    if (sts.is_put && !sts.is_newline)
                    begin
                        state_next = tcw_pkg::ST_WRITE;
                    end
                    else
                    begin
                        state_next = tcw_pkg::ST_DONE;
                    end
                end
            end
            tcw_pkg::ST_WRITE:
            begin
                cmd.write_late = 1'b1;
                state_next     = tcw_pkg::ST_DONE;
            end
            tcw_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = tcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tcw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/tcw_datapath.sv -----
module tcw_datapath #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcw_pkg::ctrl_cmd_t               cmd,
    output tcw_pkg::dp_status_t              sts,
    input  logic [tcw_pkg::CMD_W-1:0]        item_cmd,
    input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
    input  logic [tcw_pkg::COLOR_W-1:0]      fg_color,
    input  logic [tcw_pkg::COLOR_W-1:0]      bg_color,
    input  logic [tcw_pkg::COORD_W-1:0]      read_row,
    input  logic [tcw_pkg::COORD_W-1:0]      read_col,
    output logic                             result_valid,
    input  logic                             result_ready,
    output logic [tcw_pkg::DATA_W-1:0]       read_data,
    output logic [tcw_pkg::CURSOR_W-1:0]     cursor_pos,
    output logic                             range_error
);

    localparam int CELLS    = ROWS * COLS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int ROWT_W   = ROW_W + 2;
    localparam int COL_W    = $clog2(COLS + 1);
    localparam int SWP_W    = $clog2(CELLS + 1);
    localparam int COPY_END = (ROWS - 1) * COLS;
    localparam int LIN_W    = (ADDR_W > tcw_pkg::CURSOR_W) ? ADDR_W : tcw_pkg::CURSOR_W;

    // latched transaction
    logic [tcw_pkg::CMD_W-1:0]    cmd_reg;
    logic [tcw_pkg::CHAR_W-1:0]   char_reg;
    logic [tcw_pkg::COLOR_W-1:0]  fg_reg;
    logic [tcw_pkg::COLOR_W-1:0]  bg_reg;
    logic [tcw_pkg::COORD_W-1:0]  rrow_reg;
    logic [tcw_pkg::COORD_W-1:0]  rcol_reg;

    logic [ROW_W-1:0]             row_reg;
    logic [ROW_W-1:0]             row_next;
    logic [COL_W-1:0]             col_reg;
    logic [COL_W-1:0]             col_next;
    logic [tcw_pkg::CURSOR_W-1:0] cursor_reg;
    logic [tcw_pkg::CURSOR_W-1:0] cursor_next;

    logic [SWP_W-1:0]             sweep_reg;
    logic                         copy_reg;

    logic [tcw_pkg::DATA_W-1:0]   mem [CELLS];
    logic [tcw_pkg::DATA_W-1:0]   rd_data_reg;

    logic                         out_valid_reg;
    logic [tcw_pkg::DATA_W-1:0]   out_data_reg;
    logic [tcw_pkg::CURSOR_W-1:0] out_cursor_reg;
    logic                         out_err_reg;

    logic                         is_put;
    logic                         is_read;
    logic                         is_newline;
    logic                         wrap;
    logic [ROWT_W-1:0]            row_t;
    logic [COL_W-1:0]             col_t;
    logic                         need_scroll;
    logic [ROW_W-1:0]             row_fin;
    logic [ROW_W-1:0]             wr_row;
    logic [COL_W-1:0]             wr_col;
    logic [LIN_W-1:0]             wr_lin;
    logic [tcw_pkg::DATA_W-1:0]   put_data;
    logic                         rd_ok;
    logic [LIN_W-1:0]             rd_lin;
    logic [SWP_W-1:0]             sw_prev;
    logic [SWP_W-1:0]             sw_rd_addr;
    logic                         sw_copy_wr;
    logic                         sw_rd_ok;
    logic                         sweep_done;
    logic [tcw_pkg::DATA_W-1:0]   rsp_data;
    logic                         rsp_err;

    assign is_put     = (cmd_reg == tcw_pkg::CMD_PUT);
    assign is_read    = (cmd_reg == tcw_pkg::CMD_READ);
    assign is_newline = (char_reg == tcw_pkg::NEWLINE_CODE);

    // line wrap happens before the newline test
    assign wrap        = (col_reg >= COL_W'(COLS));
    assign row_t       = ROWT_W'(row_reg) + ROWT_W'(wrap) + ROWT_W'(is_newline);
    assign col_t       = (wrap || is_newline) ? '0 : col_reg;
    assign need_scroll = (row_t >= ROWT_W'(ROWS));
    assign row_fin     = need_scroll ? ROW_W'(ROWS - 1) : row_t[ROW_W-1:0];

    assign wr_row   = cmd.write_late ? row_reg : row_fin;
    assign wr_col   = cmd.write_late ? col_reg : col_t;
    assign wr_lin   = LIN_W'(wr_row) * LIN_W'(COLS) + LIN_W'(wr_col);
    assign put_data = {fg_reg, bg_reg, char_reg};

    assign rd_ok  = (rrow_reg < tcw_pkg::COORD_W'(ROWS)) && (rcol_reg < tcw_pkg::COORD_W'(COLS));
    assign rd_lin = LIN_W'(rrow_reg) * LIN_W'(COLS) + LIN_W'(rcol_reg);

    // sweep writes one cell behind the read of the cell a row below
    assign sw_prev    = sweep_reg - SWP_W'(1);
    assign sw_rd_addr = sweep_reg + SWP_W'(COLS);
    assign sw_copy_wr = copy_reg && (sw_prev < SWP_W'(COPY_END));
    assign sw_rd_ok   = copy_reg && (sweep_reg < SWP_W'(COPY_END));
    assign sweep_done = (sweep_reg == SWP_W'(CELLS));

    assign rsp_err  = is_read && !rd_ok;
    assign rsp_data = !is_read ? '0 : (!rd_ok ? tcw_pkg::ERR_DATA : rd_data_reg);

    assign sts.is_put      = is_put;
    assign sts.is_clear    = (cmd_reg == tcw_pkg::CMD_CLEAR);
    assign sts.is_read     = is_read;
    assign sts.is_newline  = is_newline;
    assign sts.need_scroll = need_scroll;
    assign sts.sweep_done  = sweep_done;
    assign sts.out_free    = !out_valid_reg || result_ready;

    always_comb
    begin
        row_next    = row_reg;
        col_next    = col_reg;
        cursor_next = cursor_reg;
        priority if (cmd.clear_pos)
        begin
            row_next    = '0;
            col_next    = '0;
            cursor_next = '0;
        end
        else if (cmd.write_now)
        begin
            row_next    = row_fin;
            col_next    = col_t + COL_W'(1);
            cursor_next = wr_lin[tcw_pkg::CURSOR_W-1:0];
        end
        else if (cmd.put_pos)
        begin
            row_next = row_fin;
            col_next = col_t;
        end
        else if (cmd.write_late)
        begin
            col_next    = col_reg + COL_W'(1);
            cursor_next = wr_lin[tcw_pkg::CURSOR_W-1:0];
        end
        else
        begin
            // position held
            row_next    = row_reg;
            col_next    = col_reg;
            cursor_next = cursor_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cmd_reg  <= item_cmd;
            char_reg <= char_code;
            fg_reg   <= fg_color;
            bg_reg   <= bg_color;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
    end

    // cell store, one write and one read port
    always_ff @(posedge clk)
    begin
        if (cmd.sweep_step && (sweep_reg != '0))
        begin
            mem[sw_prev[ADDR_W-1:0]] <= sw_copy_wr ? rd_data_reg : tcw_pkg::BLANK_CELL;
        end
        else if (cmd.write_now || cmd.write_late)
        begin
            mem[wr_lin[ADDR_W-1:0]] <= put_data;
        end
        if (cmd.sweep_step && sw_rd_ok)
        begin
            rd_data_reg <= mem[sw_rd_addr[ADDR_W-1:0]];
        end
        else if (cmd.read_issue && rd_ok)
        begin
            rd_data_reg <= mem[rd_lin[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            cursor_reg    <= '0;
            sweep_reg     <= '0;
            copy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg    <= row_next;
            col_reg    <= col_next;
            cursor_reg <= cursor_next;
            if (cmd.sweep_start)
            begin
                sweep_reg <= '0;
                copy_reg  <= cmd.sweep_copy;
            end
            else if (cmd.sweep_step && !sweep_done)
            begin
                sweep_reg <= sweep_reg + SWP_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg   <= rsp_data;
            out_cursor_reg <= cursor_next;
            out_err_reg    <= rsp_err;
        end
    end

    assign result_valid = out_valid_reg;
    assign read_data    = out_data_reg;
    assign cursor_pos   = out_cursor_reg;
    assign range_error  = out_err_reg;

endmodule

// ----- rtl/core/text_console_writer_unit.sv -----
// Text console writer: keeps a ROWS x COLS store of 16-bit text cells
// ({fg, bg, char}), a write position and a cursor, and answers every put,
// clear or read transaction with exactly one result transaction carrying the
// cell read (0xFFFF with range_error outside the screen, else 0) and the
// cursor. The cell store is a single-port-per-direction memory whose contents
// are undefined after reset, so issue a clear before reading. A put that does
// not scroll, and an unused command, load the result register from decode
// when it is free; a read first passes through the registered memory read.
// A clear walks the whole store, one cell a cycle; a put that runs past the
// bottom row copies every row up through the same port. Input is taken one
// transaction at a time; a new transaction is accepted while the previous
// result still waits in the output register.
module text_console_writer_unit #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic          clk,
    input  logic          rst_n,
    tcw_item_if.sink      item,
    tcw_result_if.source  result
);

    tcw_pkg::ctrl_cmd_t  cmd;
    tcw_pkg::dp_status_t sts;

    tcw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    tcw_datapath #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .item_cmd     (item.cmd),
        .char_code    (item.char_code),
        .fg_color     (item.fg_color),
        .bg_color     (item.bg_color),
        .read_row     (item.read_row),
        .read_col     (item.read_col),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .read_data    (result.read_data),
        .cursor_pos   (result.cursor_pos),
        .range_error  (result.range_error)
    );

endmodule

// ----- rtl/core/tcw_check.sv -----
module tcw_check #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [tcw_pkg::DATA_W-1:0]    read_data,
    input logic [tcw_pkg::CURSOR_W-1:0]  cursor_pos,
    input logic                          range_error
);

    localparam int CELLS = ROWS * COLS;

    // a waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(read_data)
            && $stable(cursor_pos) && $stable(range_error))
        else $error("result changed while stalled");

    // one transaction in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("transaction accepted while busy");

    a_error_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && range_error |-> read_data == tcw_pkg::ERR_DATA)
        else $error("range error without error data");

    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (CELLS > 2048) || (32'(cursor_pos) < CELLS))
        else $error("cursor off screen");

endmodule

bind text_console_writer_unit tcw_check #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .read_data    (result.read_data),
    .cursor_pos   (result.cursor_pos),
    .range_error  (result.range_error)
);
